### src/kvfh_pkg.sv
// types, character codes and the hash mixing function for the key/value field hasher
// used by kvfh_in_reg, kvfh_core and key_value_field_hasher; no dependencies
`timescale 1ns / 1ps

package kvfh_pkg;

  // one input transaction held in the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } kvfh_item_t;

  // result flags, highest bit first; value_hashed is bit 0 on the tuser port
  typedef struct packed {
    logic name_defaulted;
    logic negate;
    logic value_hashed;
  } kvfh_flags_t;

  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChEquals   = 8'h3D;
  localparam logic [7:0] ChCaret    = 8'h5E;
  localparam logic [7:0] ChStar     = 8'h2A;
  localparam logic [7:0] ChQuestion = 8'h3F;

  localparam logic [4:0] ShiftStep   = 5'd5;
  localparam logic [4:0] WrapLimit   = 5'd24;
  localparam logic [5:0] WordBits    = 6'd32;
  localparam logic [31:0] WrapMask   = 32'h0000_007F;

  // one hash step: xor in the sign-extended byte at shift s, with wraparound bits
  function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b,
                                           input logic [4:0] s);
    logic [31:0] sx;
    logic [31:0] res;
    logic [5:0]  rs;
    sx  = {{24{b[7]}}, b};
    rs  = WordBits - {1'b0, s};
    res = h ^ (sx << s);
    if (s > WrapLimit) begin
      res = res ^ ((sx >> rs) & WrapMask);
    end
    return res;
  endfunction

  // hash of the default name "Module", folded at elaboration
  function automatic logic [31:0] default_name_hash();
    logic [7:0]  name [6];
    logic [31:0] h;
    logic [4:0]  s;
    name[0] = 8'h4D;
    name[1] = 8'h6F;
    name[2] = 8'h64;
    name[3] = 8'h75;
    name[4] = 8'h6C;
    name[5] = 8'h65;
    h = '0;
    s = '0;
    for (int i = 0; i < 6; i++) begin
      h = mix_byte(h, name[i], s);
      s = s + ShiftStep;
    end
    return h;
  endfunction

  localparam logic [31:0] DefaultHash = default_name_hash();

endpackage

### src/key_value_field_hasher.sv
// top level of the key/value field hasher: input register, parser/hash core, result register
// depends on kvfh_pkg, kvfh_in_reg and kvfh_core
// path: a closing byte goes through the input register, then the result register, before its result
// transaction is offered; while an earlier result is not yet taken it waits in the input register
// throughput: one byte per cycle; a closing byte waits only while a result is not yet taken
// reset: synchronous rst clears the field state and both valid flags; no clearing pass
`timescale 1ns / 1ps

module key_value_field_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] name_hash, [63:32] value_hash
  output logic [2:0]  m_tuser,   // [0] value_hashed, [1] negate, [2] name_defaulted
  output logic        m_tlast    // string_end
);
  import kvfh_pkg::*;

  kvfh_item_t  s_item;
  kvfh_item_t  item;
  kvfh_flags_t flags;
  logic        item_valid;
  logic        take;
  logic [31:0] name_hash;
  logic [31:0] value_hash;

  assign s_item.text_byte   = s_tdata;
  assign s_item.end_of_text = s_tlast;

  // input register
  kvfh_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // parser, hash state and result register
  kvfh_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .name_hash  (name_hash),
    .value_hash (value_hash),
    .flags      (flags),
    .string_end (m_tlast)
  );

  // output packing
  assign m_tdata = {value_hash, name_hash};
  assign m_tuser = flags;

endmodule

### src/kvfh_in_reg.sv
// input register stage of the key/value field hasher
// depends on kvfh_pkg for the item type
`timescale 1ns / 1ps

module kvfh_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  kvfh_pkg::kvfh_item_t s_item,
  output logic               item_valid,
  output kvfh_pkg::kvfh_item_t item,
  input  logic               take
);
  import kvfh_pkg::*;

  // free when empty or when the held item moves on this cycle
  assign s_tready = !item_valid || take;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule

### src/kvfh_core.sv
// field parser, hash state and result register of the key/value field hasher
// depends on kvfh_pkg for types, character codes and mix_byte
`timescale 1ns / 1ps

module kvfh_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  kvfh_pkg::kvfh_item_t item,
  output logic                 take,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [31:0]          name_hash,
  output logic [31:0]          value_hash,
  output kvfh_pkg::kvfh_flags_t flags,
  output logic                 string_end
);
  import kvfh_pkg::*;

  logic        in_value_part, in_value_part_next;
  logic [31:0] saved_name_hash, saved_name_hash_next;
  logic        saved_name_empty, saved_name_empty_next;
  logic [31:0] running_hash, running_hash_next;
  logic [31:0] committed_hash, committed_hash_next;
  logic [4:0]  hash_shift, hash_shift_next;
  logic        seen_text, seen_text_next;
  logic        wildcard_seen, wildcard_seen_next;
  logic        caret_seen, caret_seen_next;

  logic [7:0]  c;
  logic        is_space, is_comma, is_sep, is_wild, close, out_free, step, defaulted;
  logic [31:0] mixed;

  // character classes
  assign c        = item.text_byte;
  assign is_space = (c == ChSpace) || (c == ChTab);
  assign is_comma = (c == ChComma);
  assign is_sep   = !in_value_part && ((c == ChEquals) || (c == ChCaret));
  assign is_wild  = (c == ChStar) || (c == ChQuestion);
  assign close    = item.end_of_text || is_comma;
  assign mixed    = mix_byte(running_hash, c, hash_shift);

  // an item moves on unless it closes a field while the result register is full and not being taken
  assign out_free = !m_tvalid || m_tready;
  assign take     = item_valid && (!close || out_free);
  assign step     = take;

  // next state for one byte
  always_comb begin
    in_value_part_next    = in_value_part;
    saved_name_hash_next  = saved_name_hash;
    saved_name_empty_next = saved_name_empty;
    running_hash_next     = running_hash;
    committed_hash_next   = committed_hash;
    hash_shift_next       = hash_shift;
    seen_text_next        = seen_text;
    wildcard_seen_next    = wildcard_seen;
    caret_seen_next       = caret_seen;
    if (is_comma) begin
      // separator between fields, not text
    end else if (is_sep) begin
      caret_seen_next       = caret_seen || (c == ChCaret);
      saved_name_hash_next  = committed_hash;
      saved_name_empty_next = !seen_text;
      in_value_part_next    = 1'b1;
      running_hash_next     = '0;
      committed_hash_next   = '0;
      hash_shift_next       = '0;
      seen_text_next        = 1'b0;
    end else begin
      if (in_value_part && is_wild) begin
        wildcard_seen_next = 1'b1;
      end
      // leading blanks skipped, trailing blanks hashed but not committed
      if (seen_text || !is_space) begin
        seen_text_next    = 1'b1;
        running_hash_next = mixed;
        hash_shift_next   = hash_shift + ShiftStep;
        if (!is_space) begin
          committed_hash_next = mixed;
        end
      end
    end
  end

  assign defaulted = !in_value_part_next || saved_name_empty_next;

  // field state, cleared when a field closes
  always_ff @(posedge clk) begin
    if (rst || (step && close)) begin
      in_value_part    <= 1'b0;
      saved_name_hash  <= '0;
      saved_name_empty <= 1'b1;
      running_hash     <= '0;
      committed_hash   <= '0;
      hash_shift       <= '0;
      seen_text        <= 1'b0;
      wildcard_seen    <= 1'b0;
      caret_seen       <= 1'b0;
    end else if (step) begin
      in_value_part    <= in_value_part_next;
      saved_name_hash  <= saved_name_hash_next;
      saved_name_empty <= saved_name_empty_next;
      running_hash     <= running_hash_next;
      committed_hash   <= committed_hash_next;
      hash_shift       <= hash_shift_next;
      seen_text        <= seen_text_next;
      wildcard_seen    <= wildcard_seen_next;
      caret_seen       <= caret_seen_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && close) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step && close) begin
      name_hash            <= defaulted ? DefaultHash : saved_name_hash_next;
      value_hash           <= wildcard_seen_next ? 32'd0 : committed_hash_next;
      flags.value_hashed   <= !wildcard_seen_next;
      flags.negate         <= caret_seen_next;
      flags.name_defaulted <= defaulted;
      string_end           <= item.end_of_text;
    end
  end

  // a closed field leaves clean state behind
  a_clear_after_close: assert property (@(posedge clk) disable iff (rst)
    step && close |=> !in_value_part && !seen_text && !wildcard_seen && !caret_seen
                      && (hash_shift == 5'd0))
    else $error("field state not cleared after close");

  // a wildcard-tagged value carries no hash
  a_wild_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !flags.value_hashed |-> value_hash == 32'd0)
    else $error("value hash nonzero with wildcard");

  // a defaulted name carries the default hash
  a_default_name: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && flags.name_defaulted |-> name_hash == DefaultHash)
    else $error("defaulted name hash wrong");

  // a closing byte never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !(step && close))
    else $error("pending result overwritten");

  // leading blanks never start the text
  a_blank_skip: assert property (@(posedge clk) disable iff (rst)
    step && !seen_text && is_space && !close |=> !seen_text)
    else $error("leading blank counted as text");

endmodule

### verif/tb.sv
// testbench for key_value_field_hasher: byte stream in, one hashed field result per field out
// a scoreboard class predicts each field result from the accepted bytes; depends on kvfh_pkg
`timescale 1ns / 1ps

module tb;
  import kvfh_pkg::*;

  // one predicted field result
  typedef struct {
    logic [31:0] name_hash;
    logic [31:0] value_hash;
    kvfh_flags_t flags;
    logic        string_end;
  } field_result_t;

  // tracks the parser state, predicts field results and checks them in order
  class field_hash_tracker;
    field_result_t pending_fields[$];
    int unsigned   bad_count;
    logic [31:0]   module_hash;
    logic          in_value;
    logic [31:0]   saved_name;
    logic          name_empty;
    logic [31:0]   run_hash;
    logic [31:0]   commit_hash;
    logic [4:0]    shift;
    logic          seen;
    logic          wild;
    logic          caret;

    function new();
      logic [7:0] dflt [6];
      dflt = '{8'h4D, 8'h6F, 8'h64, 8'h75, 8'h6C, 8'h65};
      bad_count   = 0;
      module_hash = '0;
      shift       = '0;
      foreach (dflt[i]) begin
        module_hash = fold_char(module_hash, dflt[i], shift);
        shift = shift + 5'd5;
      end
      restart();
    endfunction

    // xor of one sign-extended character at bit position pos, with masked wraparound bits
    function logic [31:0] fold_char(logic [31:0] acc, logic [7:0] ch, logic [4:0] pos);
      logic [31:0] ext;
      ext = {{24{ch[7]}}, ch};
      acc = acc ^ (ext << pos);
      if (pos > 5'd24) begin
        acc = acc ^ ((ext >> (32 - int'(pos))) & 32'h0000_007F);
      end
      return acc;
    endfunction

    function void clear_part();
      run_hash    = '0;
      commit_hash = '0;
      shift       = '0;
      seen        = 1'b0;
    endfunction

    function void restart();
      in_value   = 1'b0;
      saved_name = '0;
      name_empty = 1'b1;
      wild       = 1'b0;
      caret      = 1'b0;
      clear_part();
    endfunction

    // advance the parser on one accepted byte, queue a result when a field closes
    function void note_byte(logic [7:0] ch, logic last);
      logic          close;
      logic          blank;
      logic          dflt;
      field_result_t res;
      close = last;
      blank = (ch == ChSpace) || (ch == ChTab);
      if (ch == ChComma) begin
        close = 1'b1;
      end else if (!in_value && (ch == ChEquals || ch == ChCaret)) begin
        if (ch == ChCaret) caret = 1'b1;
        saved_name = commit_hash;
        name_empty = !seen;
        in_value   = 1'b1;
        clear_part();
      end else begin
        if (in_value && (ch == ChStar || ch == ChQuestion)) wild = 1'b1;
        // leading blanks are skipped, trailing blanks are hashed but not committed
        if (seen || !blank) begin
          seen     = 1'b1;
          run_hash = fold_char(run_hash, ch, shift);
          shift    = shift + 5'd5;
          if (!blank) commit_hash = run_hash;
        end
      end
      if (close) begin
        dflt                     = !in_value || name_empty;
        res.name_hash            = dflt ? module_hash : saved_name;
        res.value_hash           = wild ? 32'h0 : commit_hash;
        res.flags.value_hashed   = !wild;
        res.flags.negate         = caret;
        res.flags.name_defaulted = dflt;
        res.string_end           = last;
        pending_fields.push_back(res);
        restart();
      end
    endfunction

    function void flag_error(string what, logic [63:0] exp_v, logic [63:0] act_v);
      bad_count++;
      if (bad_count <= 10) begin
        $display("%0t ERROR %s: expected %h actual %h", $realtime, what, exp_v, act_v);
      end
    endfunction

    // compare one result transaction against the oldest prediction
    function void check_field(logic [63:0] data, logic [2:0] user, logic last);
      field_result_t exp_r;
      if (pending_fields.size() == 0) begin
        flag_error("unexpected result", 64'h0, data);
        return;
      end
      exp_r = pending_fields.pop_front();
      if (data[31:0] !== exp_r.name_hash)
        flag_error("name_hash", 64'(exp_r.name_hash), 64'(data[31:0]));
      if (data[63:32] !== exp_r.value_hash)
        flag_error("value_hash", 64'(exp_r.value_hash), 64'(data[63:32]));
      if (user[0] !== exp_r.flags.value_hashed)
        flag_error("value_hashed", 64'(exp_r.flags.value_hashed), 64'(user[0]));
      if (user[1] !== exp_r.flags.negate)
        flag_error("negate", 64'(exp_r.flags.negate), 64'(user[1]));
      if (user[2] !== exp_r.flags.name_defaulted)
        flag_error("name_defaulted", 64'(exp_r.flags.name_defaulted), 64'(user[2]));
      if (last !== exp_r.string_end)
        flag_error("string_end", 64'(exp_r.string_end), 64'(last));
    endfunction

    function void flush_leftover();
      while (pending_fields.size() > 0) begin
        void'(pending_fields.pop_front());
        flag_error("missing result", 64'h0, 64'h0);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  field_hash_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_left;
  int unsigned bytes_sent;

  key_value_field_hasher DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready  = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_field(m_tdata, m_tuser, m_tlast);
    end
  end

  // offer one byte, with a random gap first, and wait until it is taken
  task automatic send_byte(input logic [7:0] ch, input logic last);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = ch;
    s_tlast  = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_byte(ch, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string txt, input logic last_on_end);
    for (int i = 0; i < txt.len(); i++) begin
      send_byte(txt[i], last_on_end && (i == txt.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_blank();
    return ($urandom_range(0, 1) != 0) ? ChSpace : ChTab;
  endfunction

  // a text character; separators only where they are ordinary text
  function automatic logic [7:0] pick_text_char(input bit allow_seps);
    logic [7:0]  ch;
    int unsigned r;
    r = $urandom_range(0, 11);
    if (r == 0) begin
      ch = pick_blank();
    end else if (r == 1) begin
      ch = ($urandom_range(0, 1) != 0) ? ChStar : ChQuestion;
    end else if (r == 2 && allow_seps) begin
      ch = ($urandom_range(0, 1) != 0) ? ChEquals : ChCaret;
    end else begin
      do ch = 8'($urandom_range(1, 255));
      while (ch == ChComma || ch == ChEquals || ch == ChCaret);
    end
    return ch;
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
  endfunction

  // one field: mostly well formed with random content, sometimes raw noise
  task automatic send_random_field();
    logic [7:0]  fld[$];
    logic        end_flag;
    int unsigned mode;
    int unsigned r;
    end_flag = 1'b0;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(0, 9);
        case (r)
          0: fld.push_back(ChComma);
          1: fld.push_back(ChEquals);
          2: fld.push_back(ChCaret);
          3: fld.push_back(pick_blank());
          default: fld.push_back(8'($urandom_range(1, 255)));
        endcase
      end
      end_flag = ($urandom_range(0, 7) == 0);
    end else begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(0, 2)) fld.push_back(pick_blank());
      if (mode != 2) begin
        repeat (pick_len()) fld.push_back(pick_text_char(1'b0));
        repeat ($urandom_range(0, 2)) fld.push_back(pick_blank());
        fld.push_back((mode == 0) ? ChEquals : ChCaret);
        repeat ($urandom_range(0, 2)) fld.push_back(pick_blank());
      end
      repeat (pick_len()) fld.push_back(pick_text_char(mode != 2));
      repeat ($urandom_range(0, 2)) fld.push_back(pick_blank());
      r = $urandom_range(0, 5);
      if (r == 0 && fld.size() > 0) begin
        end_flag = 1'b1;
      end else begin
        fld.push_back(ChComma);
        end_flag = (r <= 1);
      end
    end
    foreach (fld[i]) send_byte(fld[i], end_flag && (i == fld.size() - 1));
  endtask

  // main sequence
  initial begin
    int unsigned wait_cycles;
    tracker       = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tlast       = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 0;
    bytes_sent    = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // directed: trimming, caret, wildcards on both sides, empty parts, byte extremes
    send_text(" \tz^*,", 1'b0);
    send_text("?=", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(" \t,", 1'b0);
    send_byte(ChEquals, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(ChComma, 1'b0);
    send_text(" ^,", 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(ChComma, 1'b0);
    send_text("k=a=?", 1'b1);
    send_byte(ChComma, 1'b1);

    // random phases: receiver mostly idles (with a long hold-off), then sender mostly idles, then no idling
    send_idle_pct = 32;
    recv_idle_pct = 67;
    hold_left     = 400;
    while (bytes_sent < 525) send_random_field();
    send_idle_pct = 67;
    recv_idle_pct = 32;
    while (bytes_sent < 1025) send_random_field();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_sent < 1525) send_random_field();
    s_tvalid = 1'b0;

    // drain
    wait_cycles = 0;
    while (tracker.pending_fields.size() > 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    tracker.flush_leftover();
    if (tracker.bad_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
